// ----- rtl/jhss_pkg.sv -----
// shared types, constants and helpers for the huffman symbol statistics core
package jhss_pkg;

  // defaults for the top-level parameters
  localparam int unsigned TABLE_COUNT_DEF     = 4;
  localparam int unsigned COMPONENT_COUNT_DEF = 4;
  localparam int unsigned COEF_BITS_DEF       = 12;
  localparam int unsigned COUNT_BITS_DEF      = 32;

  localparam int unsigned DC_BINS       = 16;
  localparam int unsigned AC_BINS       = 256;
  localparam int unsigned ZRL_LEN       = 16;
  localparam int unsigned COEF_BITS_MAX = 16;
  // a dc difference needs one bit more than a coefficient
  localparam int unsigned MAG_W         = COEF_BITS_MAX + 1;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned OQ_DEPTH      = 4;

  localparam logic [7:0] SYM_ZRL  = 8'hF0;
  localparam logic [7:0] SYM_EOB  = 8'h00;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] RUN_MAX  = 6'd63;

  typedef enum logic [1:0] {
    OP_COEF  = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // request to a histogram memory: increment or read-and-clear
  typedef enum logic [1:0] {
    HOP_NONE = 2'd0,
    HOP_BUMP = 2'd1,
    HOP_TAKE = 2'd2
  } hist_op_e;

  // where a read result's count comes from
  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_DC     = 2'd1,
    SRC_AC     = 2'd2
  } res_src_e;

  // bit length of a magnitude, held at 15
  function automatic logic [3:0] size_cat(input logic [MAG_W-1:0] mag);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag[i]) begin
        n = 5'(i + 1);
      end
    end
    if (n > 5'd15) begin
      n = 5'd15;
    end
    return n[3:0];
  endfunction

endpackage

// ----- rtl/jhss_hist_mem.sv -----
// histogram memory with saturating read-modify-write, forwarding and clearing pass
module jhss_hist_mem #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  jhss_pkg::hist_op_e       op_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [COUNT_BITS-1:0]    rdata_o,
  output logic                     busy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic                  clr_busy_q, clr_busy_d;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;
  jhss_pkg::hist_op_e    s1_op_q;
  logic [AW-1:0]         s1_addr_q;
  logic                  fwd_q, fwd_d;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] rdata_q;

  logic [COUNT_BITS-1:0] old_val;
  logic [COUNT_BITS-1:0] new_val;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [COUNT_BITS-1:0] wd;

  // the entry read last cycle may have been written by the request ahead of it
  assign old_val = fwd_q ? fwd_data_q : rdata_q;

  always_comb begin
    if (s1_op_q == jhss_pkg::HOP_BUMP) begin
      new_val = (old_val == '1) ? old_val : old_val + 1'b1;
    end else begin
      new_val = '0;
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = '0;
    end else begin
      we = (s1_op_q != jhss_pkg::HOP_NONE);
      wa = s1_addr_q;
      wd = new_val;
    end
  end

  assign fwd_d = (op_i != jhss_pkg::HOP_NONE) && (s1_op_q != jhss_pkg::HOP_NONE) &&
                 (s1_addr_q == addr_i);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q    <= mem[addr_i];
    s1_addr_q  <= addr_i;
    fwd_data_q <= new_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_op_q    <= jhss_pkg::HOP_NONE;
      fwd_q      <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      s1_op_q    <= op_i;
      fwd_q      <= fwd_d;
    end
  end

  assign rdata_o = old_val;
  assign busy_o  = clr_busy_q;

  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> op_i == jhss_pkg::HOP_NONE)
    else $error("histogram request during clearing pass");

  a_fwd_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(s1_op_q != jhss_pkg::HOP_NONE))
    else $error("forwarding without a preceding write");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_op_q == jhss_pkg::HOP_TAKE) |=> fwd_data_q == '0)
    else $error("read-and-clear did not write zero");

  a_clear_ends_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> $past(clr_addr_q) == LAST_ADDR)
    else $error("clearing pass ended early");

endmodule

// ----- rtl/jpeg_huffman_symbol_statistics_core.sv -----
// huffman symbol statistics core: dc/ac symbol histograms for a baseline encoder
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------------
//  in      | request   | in_valid_i / in_stall_o | opcode, coef, position, component, tables, bin
//  out     | result    | out_valid_o/out_stall_i | bin_count_o, table_in_use_o
//
// one request per cycle unless in_stall_o is high; a read result is registered in stage 1, then queued.
// each histogram update is one read-modify-write on a memory port, with forwarding between
// back-to-back requests to the same bin; zrl counts sit in registers.
// after reset a clearing pass over both histogram memories holds in_stall_o high.
// in_stall_o also rises while the four-entry result queue could not take another result.
module jpeg_huffman_symbol_statistics_core #(
  parameter int unsigned TABLE_COUNT     = jhss_pkg::TABLE_COUNT_DEF,
  parameter int unsigned COMPONENT_COUNT = jhss_pkg::COMPONENT_COUNT_DEF,
  parameter int unsigned COEF_BITS       = jhss_pkg::COEF_BITS_DEF,
  parameter int unsigned COUNT_BITS      = jhss_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic signed [COEF_BITS-1:0] coef_value_i,
  input  logic [5:0]                  zigzag_position_i,
  input  logic [1:0]                  component_index_i,
  input  logic [1:0]                  dc_table_select_i,
  input  logic [1:0]                  ac_table_select_i,
  input  logic                        read_is_ac_i,
  input  logic [7:0]                  read_symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 bin_count_o,
  output logic                        table_in_use_o
);

  localparam int unsigned TBL_W    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int unsigned COMP_W   = (COMPONENT_COUNT > 1) ? $clog2(COMPONENT_COUNT) : 1;
  localparam int unsigned DC_DEPTH = TABLE_COUNT * jhss_pkg::DC_BINS;
  localparam int unsigned AC_DEPTH = TABLE_COUNT * jhss_pkg::AC_BINS;
  localparam int unsigned DC_AW    = $clog2(DC_DEPTH);
  localparam int unsigned AC_AW    = $clog2(AC_DEPTH);
  localparam int unsigned MAG_W    = jhss_pkg::MAG_W;
  localparam int unsigned OUT_W    = jhss_pkg::OUT_W;
  localparam int unsigned EXT_W    = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
  localparam int unsigned OQ_DEPTH = jhss_pkg::OQ_DEPTH;
  localparam int unsigned OQ_PW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = OQ_PW + 1;
  localparam logic [2:0]  TBL_LIM  = 3'(TABLE_COUNT);
  localparam logic [2:0]  COMP_LIM = 3'(COMPONENT_COUNT);

  // stage 0 state
  logic signed [COEF_BITS-1:0] pred_q [COMPONENT_COUNT];
  logic signed [COEF_BITS-1:0] pred_d [COMPONENT_COUNT];
  logic [COUNT_BITS-1:0]       zrl_q  [TABLE_COUNT];
  logic [COUNT_BITS-1:0]       zrl_d  [TABLE_COUNT];
  logic [5:0]                  run_q, run_d;
  logic [TABLE_COUNT-1:0]      dcf_q, dcf_d;
  logic [TABLE_COUNT-1:0]      acf_q, acf_d;

  // stage 1 result tracking
  logic                        s1_res_q, s1_res_d;
  jhss_pkg::res_src_e          s1_src_q, s1_src_d;
  logic                        s1_used_q, s1_used_d;
  logic [COUNT_BITS-1:0]       s1_direct_q, s1_direct_d;

  // result queue
  logic [OUT_W-1:0]            oq_count_q [OQ_DEPTH];
  logic                        oq_used_q  [OQ_DEPTH];
  logic [OQ_PW-1:0]            oq_wr_q, oq_rd_q;
  logic [OQ_CW-1:0]            oq_cnt_q, oq_cnt_d;

  jhss_pkg::op_e               op;
  jhss_pkg::hist_op_e          dc_op, ac_op;
  logic [DC_AW-1:0]            dc_addr;
  logic [AC_AW-1:0]            ac_addr;
  logic [COUNT_BITS-1:0]       dc_rdata, ac_rdata;
  logic                        dc_busy, ac_busy;

  logic                        accept;
  logic                        dct_ok, act_ok, tsel_ok, comp_ok;
  logic [1:0]                  tidx;
  logic [TBL_W-1:0]            tsel, dct_sel;
  logic [COMP_W-1:0]           comp_sel;
  logic signed [COEF_BITS-1:0] pred;
  logic signed [MAG_W-1:0]     val_x, diff, cat_in;
  logic [MAG_W-1:0]            mag;
  logic [3:0]                  cat;
  logic                        is_dc, is_zero;
  logic [1:0]                  zrl_k;
  logic [3:0]                  run_rem;
  logic [COUNT_BITS-1:0]       zrl_cur;
  logic [COUNT_BITS:0]         zrl_sum;
  logic [COUNT_BITS-1:0]       zrl_sat;
  logic [3:0]                  dc_sym;
  logic [7:0]                  ac_sym;
  logic [5:0]                  dc_addr_full;
  logic [9:0]                  ac_addr_full;

  logic                        push, pop;
  logic [COUNT_BITS-1:0]       res_count;
  logic [EXT_W-1:0]            res_ext;

  assign op     = jhss_pkg::op_e'(opcode_i);
  assign accept = in_valid_i && !in_stall_o;

  assign dct_ok   = {1'b0, dc_table_select_i} < TBL_LIM;
  assign act_ok   = {1'b0, ac_table_select_i} < TBL_LIM;
  assign comp_ok  = {1'b0, component_index_i} < COMP_LIM;
  assign tidx     = (op == jhss_pkg::OP_READ) ? dc_table_select_i : ac_table_select_i;
  assign tsel_ok  = {1'b0, tidx} < TBL_LIM;
  assign tsel     = tidx[TBL_W-1:0];
  assign dct_sel  = dc_table_select_i[TBL_W-1:0];
  assign comp_sel = component_index_i[COMP_W-1:0];

  // dc difference and size category share one encoder
  assign pred    = comp_ok ? pred_q[comp_sel] : '0;
  assign val_x   = MAG_W'(coef_value_i);
  assign diff    = val_x - MAG_W'(pred);
  assign is_dc   = (zigzag_position_i == '0);
  assign is_zero = (coef_value_i == '0);
  assign cat_in  = is_dc ? diff : val_x;
  assign mag     = cat_in[MAG_W-1] ? MAG_W'(-cat_in) : MAG_W'(cat_in);
  assign cat     = jhss_pkg::size_cat(mag);

  // full 16-zero runs become zrl symbols, the rest goes into the run/size symbol
  assign zrl_k   = 2'(run_q / jhss_pkg::ZRL_LEN);
  assign run_rem = 4'(run_q % jhss_pkg::ZRL_LEN);
  assign zrl_cur = zrl_q[tsel];
  assign zrl_sum = {1'b0, zrl_cur} + (COUNT_BITS + 1)'(zrl_k);
  assign zrl_sat = zrl_sum[COUNT_BITS] ? '1 : zrl_sum[COUNT_BITS-1:0];

  assign dc_sym = (op == jhss_pkg::OP_READ) ? read_symbol_i[3:0] : cat;
  always_comb begin
    if (op == jhss_pkg::OP_READ) begin
      ac_sym = read_symbol_i;
    end else if (is_zero) begin
      ac_sym = jhss_pkg::SYM_EOB;
    end else begin
      ac_sym = {run_rem, cat};
    end
  end
  assign dc_addr_full = {dc_table_select_i, dc_sym};
  assign ac_addr_full = {tidx, ac_sym};
  assign dc_addr      = dc_addr_full[DC_AW-1:0];
  assign ac_addr      = ac_addr_full[AC_AW-1:0];

  always_comb begin
    dc_op       = jhss_pkg::HOP_NONE;
    ac_op       = jhss_pkg::HOP_NONE;
    pred_d      = pred_q;
    zrl_d       = zrl_q;
    run_d       = run_q;
    dcf_d       = dcf_q;
    acf_d       = acf_q;
    s1_res_d    = 1'b0;
    s1_src_d    = jhss_pkg::SRC_DIRECT;
    s1_used_d   = 1'b0;
    s1_direct_d = '0;
    if (accept) begin
      unique case (op)
        jhss_pkg::OP_COEF: begin
          if (is_dc) begin
            if (comp_ok) begin
              pred_d[comp_sel] = coef_value_i;
            end
            if (dct_ok) begin
              dc_op          = jhss_pkg::HOP_BUMP;
              dcf_d[dct_sel] = 1'b1;
            end
            if (act_ok) begin
              acf_d[tsel] = 1'b1;
            end
            run_d = '0;
          end else if (is_zero) begin
            if (zigzag_position_i == jhss_pkg::LAST_POS) begin
              if (act_ok) begin
                ac_op = jhss_pkg::HOP_BUMP;
              end
              run_d = '0;
            end else if (run_q != jhss_pkg::RUN_MAX) begin
              run_d = run_q + 1'b1;
            end
          end else begin
            if (act_ok) begin
              ac_op = jhss_pkg::HOP_BUMP;
              if (zrl_k != '0) begin
                zrl_d[tsel] = zrl_sat;
              end
            end
            run_d = '0;
          end
        end
        jhss_pkg::OP_READ: begin
          s1_res_d = 1'b1;
          if (tsel_ok) begin
            if (read_is_ac_i) begin
              s1_used_d = acf_q[tsel];
              if (read_symbol_i == jhss_pkg::SYM_ZRL) begin
                s1_direct_d = zrl_cur;
                zrl_d[tsel] = '0;
              end else begin
                ac_op    = jhss_pkg::HOP_TAKE;
                s1_src_d = jhss_pkg::SRC_AC;
              end
            end else begin
              s1_used_d = dcf_q[tsel];
              // dc bins stop at 15, higher symbols read as zero
              if (read_symbol_i[7:4] == '0) begin
                dc_op    = jhss_pkg::HOP_TAKE;
                s1_src_d = jhss_pkg::SRC_DC;
              end
            end
          end
        end
        jhss_pkg::OP_START: begin
          for (int c = 0; c < COMPONENT_COUNT; c++) begin
            pred_d[c] = '0;
          end
          run_d = '0;
        end
        jhss_pkg::OP_NOP: begin
        end
      endcase
    end
  end

  jhss_hist_mem #(
    .DEPTH      (DC_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dc_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (dc_op),
    .addr_i  (dc_addr),
    .rdata_o (dc_rdata),
    .busy_o  (dc_busy)
  );

  jhss_hist_mem #(
    .DEPTH      (AC_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_ac_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (ac_op),
    .addr_i  (ac_addr),
    .rdata_o (ac_rdata),
    .busy_o  (ac_busy)
  );

  always_comb begin
    case (s1_src_q)
      jhss_pkg::SRC_DC: res_count = dc_rdata;
      jhss_pkg::SRC_AC: res_count = ac_rdata;
      default:          res_count = s1_direct_q;
    endcase
  end
  assign res_ext = EXT_W'(res_count);

  assign push     = s1_res_q;
  assign pop      = out_valid_o && !out_stall_i;
  assign oq_cnt_d = oq_cnt_q + OQ_CW'(push) - OQ_CW'(pop);

  // room is kept for the result still in flight behind a new request
  assign in_stall_o = dc_busy || ac_busy ||
                      ((oq_cnt_q + OQ_CW'(s1_res_q)) >= OQ_CW'(OQ_DEPTH));

  always_ff @(posedge clk_i) begin
    s1_src_q    <= s1_src_d;
    s1_used_q   <= s1_used_d;
    s1_direct_q <= s1_direct_d;
    if (push) begin
      oq_count_q[oq_wr_q] <= res_ext[OUT_W-1:0];
      oq_used_q[oq_wr_q]  <= s1_used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COMPONENT_COUNT; c++) begin
        pred_q[c] <= '0;
      end
      for (int t = 0; t < TABLE_COUNT; t++) begin
        zrl_q[t] <= '0;
      end
      run_q    <= '0;
      dcf_q    <= '0;
      acf_q    <= '0;
      s1_res_q <= 1'b0;
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      pred_q   <= pred_d;
      zrl_q    <= zrl_d;
      run_q    <= run_d;
      dcf_q    <= dcf_d;
      acf_q    <= acf_d;
      s1_res_q <= s1_res_d;
      oq_cnt_q <= oq_cnt_d;
      if (push) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
    end
  end

  assign out_valid_o    = (oq_cnt_q != '0);
  assign bin_count_o    = oq_count_q[oq_rd_q];
  assign table_in_use_o = oq_used_q[oq_rd_q];

  a_stall_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dc_busy || ac_busy) |-> in_stall_o)
    else $error("request taken during clearing pass");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (oq_cnt_q < OQ_CW'(OQ_DEPTH)) || pop)
    else $error("result queue overflow");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == jhss_pkg::OP_READ)) |=> s1_res_q)
    else $error("read request lost its result");

  a_result_only_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op != jhss_pkg::OP_READ)) |=> !s1_res_q)
    else $error("result from a non-read request");

endmodule

// ----- test/jhss_stats_monitor.sv -----
// channel monitor: predicts each bin read of the statistics core and compares it
`timescale 1ns / 100ps
module jhss_stats_monitor #(
  parameter int unsigned COEF_W = jhss_pkg::COEF_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               opcode_i,
  input  logic signed [COEF_W-1:0] coef_value_i,
  input  logic [5:0]               zigzag_position_i,
  input  logic [1:0]               component_index_i,
  input  logic [1:0]               dc_table_select_i,
  input  logic [1:0]               ac_table_select_i,
  input  logic                     read_is_ac_i,
  input  logic [7:0]               read_symbol_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [31:0]              bin_count_i,
  input  logic                     table_in_use_i,
  output int                       errors_o,
  output int                       outstanding_o
);

  localparam int unsigned TABLES = jhss_pkg::TABLE_COUNT_DEF;
  localparam int unsigned COMPS  = jhss_pkg::COMPONENT_COUNT_DEF;

  typedef struct packed {
    logic [31:0] count;
    logic        used;
  } bin_reading_t;

  logic [31:0]              dc_counts [TABLES][jhss_pkg::DC_BINS];
  logic [31:0]              ac_counts [TABLES][jhss_pkg::AC_BINS];
  logic signed [COEF_W-1:0] dc_last   [COMPS];
  logic [5:0]               pending_zeros;
  logic [TABLES-1:0]        dc_seen;
  logic [TABLES-1:0]        ac_seen;
  bin_reading_t             bin_reads_due[$];
  int                       mismatches;

  function automatic logic [3:0] magnitude_class(input int v);
    int a;
    int n;
    a = (v < 0) ? -v : v;
    n = 0;
    while (a != 0) begin
      a = a >> 1;
      n++;
    end
    return (n > 15) ? 4'd15 : 4'(n);
  endfunction

  function automatic logic [31:0] count_up(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  task automatic account_coefficient(input logic signed [COEF_W-1:0] value,
                                     input logic [5:0] pos, input logic [1:0] comp,
                                     input logic [1:0] dct, input logic [1:0] act);
    int         diff;
    logic [3:0] cls;
    logic [7:0] sym;
    if (pos == 6'd0) begin
      diff = int'(value) - int'(dc_last[comp]);
      dc_last[comp] = value;
      cls = magnitude_class(diff);
      dc_counts[dct][cls] = count_up(dc_counts[dct][cls]);
      dc_seen[dct] = 1'b1;
      ac_seen[act] = 1'b1;
      pending_zeros = '0;
    end else if (value == '0) begin
      if (pos == jhss_pkg::LAST_POS) begin
        ac_counts[act][jhss_pkg::SYM_EOB] = count_up(ac_counts[act][jhss_pkg::SYM_EOB]);
        pending_zeros = '0;
      end else if (pending_zeros != jhss_pkg::RUN_MAX) begin
        pending_zeros = pending_zeros + 6'd1;
      end
    end else begin
      // each full sixteen zeros before a nonzero costs one zrl
      while (pending_zeros >= 6'(jhss_pkg::ZRL_LEN)) begin
        ac_counts[act][jhss_pkg::SYM_ZRL] = count_up(ac_counts[act][jhss_pkg::SYM_ZRL]);
        pending_zeros = pending_zeros - 6'(jhss_pkg::ZRL_LEN);
      end
      sym = {pending_zeros[3:0], magnitude_class(int'(value))};
      ac_counts[act][sym] = count_up(ac_counts[act][sym]);
      pending_zeros = '0;
    end
  endtask

  task automatic take_bin(input logic [1:0] tbl, input logic is_ac, input logic [7:0] sym,
                          output bin_reading_t r);
    r = '0;
    if (is_ac) begin
      r.used = ac_seen[tbl];
      r.count = ac_counts[tbl][sym];
      ac_counts[tbl][sym] = '0;
    end else begin
      r.used = dc_seen[tbl];
      // dc bins above 15 read as zero and are left alone
      if (sym < jhss_pkg::DC_BINS) begin
        r.count = dc_counts[tbl][sym[3:0]];
        dc_counts[tbl][sym[3:0]] = '0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor_seq
    bin_reading_t want;
    if (!rst_ni) begin
      foreach (dc_counts[t, b]) dc_counts[t][b] = '0;
      foreach (ac_counts[t, b]) ac_counts[t][b] = '0;
      foreach (dc_last[c]) dc_last[c] = '0;
      pending_zeros = '0;
      dc_seen = '0;
      ac_seen = '0;
      bin_reads_due.delete();
      mismatches = 0;
      errors_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (jhss_pkg::op_e'(opcode_i))
          jhss_pkg::OP_COEF: begin
            account_coefficient(coef_value_i, zigzag_position_i, component_index_i,
                                dc_table_select_i, ac_table_select_i);
          end
          jhss_pkg::OP_READ: begin
            take_bin(dc_table_select_i, read_is_ac_i, read_symbol_i, want);
            bin_reads_due.insert(bin_reads_due.size(), want);
          end
          jhss_pkg::OP_START: begin
            foreach (dc_last[c]) dc_last[c] = '0;
            pending_zeros = '0;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (bin_reads_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got bin_count %0d table_in_use %0b",
                   $time, bin_count_i, table_in_use_i);
        end else begin
          want = bin_reads_due.pop_front();
          if (bin_count_i !== want.count) begin
            mismatches++;
            $display("%0t: bin_count mismatch: expected %0d, got %0d",
                     $time, want.count, bin_count_i);
          end
          if (table_in_use_i !== want.used) begin
            mismatches++;
            $display("%0t: table_in_use mismatch: expected %0b, got %0b",
                     $time, want.used, table_in_use_i);
          end
        end
      end
      errors_o <= mismatches;
      outstanding_o <= bin_reads_due.size();
    end
  end

endmodule

// ----- test/tb_jpeg_huffman_symbol_statistics_core.sv -----
// stimulus and verdict for the huffman symbol statistics core
`timescale 1ns / 100ps
module tb_jpeg_huffman_symbol_statistics_core;

  localparam int unsigned COEF_W = jhss_pkg::COEF_BITS_DEF;
  localparam int ITEM_TARGET  = 1900;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    jhss_pkg::op_e            op;
    logic signed [COEF_W-1:0] coef;
    logic [5:0]               pos;
    logic [1:0]               comp;
    logic [1:0]               dct;
    logic [1:0]               act;
    logic                     is_ac;
    logic [7:0]               sym;
  } request_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               opcode = jhss_pkg::OP_NOP;
  logic signed [COEF_W-1:0] coef_value = '0;
  logic [5:0]               zigzag_position = '0;
  logic [1:0]               component_index = '0;
  logic [1:0]               dc_table_select = '0;
  logic [1:0]               ac_table_select = '0;
  logic                     read_is_ac = 1'b0;
  logic [7:0]               read_symbol = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [31:0]              bin_count;
  logic                     table_in_use;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int rx_hold_left;
  int sent = 0;
  int idle_cycles;
  int errors;
  int outstanding;

  jpeg_huffman_symbol_statistics_core u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .coef_value_i      (coef_value),
    .zigzag_position_i (zigzag_position),
    .component_index_i (component_index),
    .dc_table_select_i (dc_table_select),
    .ac_table_select_i (ac_table_select),
    .read_is_ac_i      (read_is_ac),
    .read_symbol_i     (read_symbol),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .bin_count_o       (bin_count),
    .table_in_use_o    (table_in_use)
  );

  jhss_stats_monitor #(.COEF_W(COEF_W)) u_stats_monitor (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .opcode_i          (opcode),
    .coef_value_i      (coef_value),
    .zigzag_position_i (zigzag_position),
    .component_index_i (component_index),
    .dc_table_select_i (dc_table_select),
    .ac_table_select_i (ac_table_select),
    .read_is_ac_i      (read_is_ac),
    .read_symbol_i     (read_symbol),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .bin_count_i       (bin_count),
    .table_in_use_i    (table_in_use),
    .errors_o          (errors),
    .outstanding_o     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fields a request ignores still get random bits
  function automatic request_t noise_request();
    request_t r;
    r.op    = jhss_pkg::op_e'($urandom_range(3));
    r.coef  = COEF_W'($urandom);
    r.pos   = 6'($urandom);
    r.comp  = 2'($urandom);
    r.dct   = 2'($urandom);
    r.act   = 2'($urandom);
    r.is_ac = 1'($urandom);
    r.sym   = 8'($urandom);
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] nonzero_coef();
    int pick;
    int m;
    pick = $urandom_range(99);
    if (pick < 60) m = $urandom_range(1, 7);
    else if (pick < 85) m = $urandom_range(1, 255);
    else m = $urandom_range(1, 2047);
    if ($urandom_range(1) == 1) m = -m;
    if (pick == 99) m = -2048;
    return COEF_W'(m);
  endfunction

  task automatic offer(input request_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= r.op;
    coef_value      <= r.coef;
    zigzag_position <= r.pos;
    component_index <= r.comp;
    dc_table_select <= r.dct;
    ac_table_select <= r.act;
    read_is_ac      <= r.is_ac;
    read_symbol     <= r.sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_op(input jhss_pkg::op_e op);
    request_t r;
    r = noise_request();
    r.op = op;
    offer(r);
  endtask

  task automatic send_coef(input logic [5:0] pos, input logic signed [COEF_W-1:0] value,
                           input logic [1:0] comp, input logic [1:0] dct,
                           input logic [1:0] act);
    request_t r;
    r = noise_request();
    r.op   = jhss_pkg::OP_COEF;
    r.pos  = pos;
    r.coef = value;
    r.comp = comp;
    r.dct  = dct;
    r.act  = act;
    offer(r);
  endtask

  task automatic send_read(input logic [1:0] tbl, input logic is_ac, input logic [7:0] sym);
    request_t r;
    r = noise_request();
    r.op    = jhss_pkg::OP_READ;
    r.dct   = tbl;
    r.is_ac = is_ac;
    r.sym   = sym;
    offer(r);
  endtask

  task automatic send_reads(input int n);
    logic       is_ac;
    logic [7:0] sym;
    int         pick;
    repeat (n) begin
      is_ac = 1'($urandom);
      pick = $urandom_range(99);
      if (is_ac) begin
        if (pick < 40) sym = {4'($urandom), 4'($urandom_range(1, 12))};
        else if (pick < 50) sym = jhss_pkg::SYM_ZRL;
        else if (pick < 60) sym = jhss_pkg::SYM_EOB;
        else sym = 8'($urandom);
      end else begin
        sym = (pick < 70) ? 8'($urandom_range(0, 12)) : 8'($urandom);
      end
      send_read(2'($urandom), is_ac, sym);
    end
  endtask

  // one block in zigzag order, now and then cut short
  task automatic send_block();
    logic [1:0]               comp;
    logic [1:0]               dct;
    logic [1:0]               act;
    int                       last;
    int                       density;
    logic signed [COEF_W-1:0] value;
    comp = 2'($urandom);
    dct = 2'($urandom);
    act = 2'($urandom);
    last = ($urandom_range(9) == 0) ? $urandom_range(1, 62) : 63;
    density = $urandom_range(3, 60);
    value = ($urandom_range(99) < 20) ? COEF_W'($urandom) : nonzero_coef();
    send_coef(6'd0, value, comp, dct, act);
    for (int p = 1; p <= last; p++) begin
      value = ($urandom_range(99) < density) ? nonzero_coef() : '0;
      send_coef(6'(p), value, comp, dct, act);
    end
  endtask

  // zeros that never reach the last position, so the run grows past a zrl or saturates
  task automatic send_long_run();
    logic [1:0] comp;
    logic [1:0] dct;
    logic [1:0] act;
    comp = 2'($urandom);
    dct = 2'($urandom);
    act = 2'($urandom);
    repeat ($urandom_range(16, 80)) send_coef(6'($urandom_range(1, 62)), '0, comp, dct, act);
    send_coef(6'($urandom_range(1, 63)), nonzero_coef(), comp, dct, act);
  endtask

  task automatic random_traffic(input int upto);
    int pick;
    while (sent < upto) begin
      pick = $urandom_range(99);
      if (pick < 55) send_block();
      else if (pick < 80) send_reads($urandom_range(3, 8));
      else if (pick < 86) send_long_run();
      else if (pick < 90) send_op(jhss_pkg::OP_START);
      else if (pick < 95) send_op(jhss_pkg::OP_NOP);
      else repeat ($urandom_range(1, 5)) offer(noise_request());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
        out_stall <= 1'b1;
        repeat (rx_hold_left) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    request_t r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 9;
    rx_idle_pct = 73;

    // extremes of the dc difference, run/size, eob, nop and reads of every kind
    send_op(jhss_pkg::OP_START);
    send_coef(6'd0, COEF_W'(2047), 2'd0, 2'd0, 2'd1);
    send_coef(6'd0, COEF_W'(-2048), 2'd0, 2'd3, 2'd2);
    send_coef(6'd0, '0, 2'd3, 2'd1, 2'd0);
    send_coef(6'd1, COEF_W'(-1), 2'd3, 2'd1, 2'd3);
    send_coef(6'd2, '0, 2'd3, 2'd1, 2'd3);
    send_coef(6'd3, '0, 2'd3, 2'd1, 2'd3);
    send_coef(6'd4, '0, 2'd3, 2'd1, 2'd3);
    send_coef(6'd5, COEF_W'(2047), 2'd3, 2'd1, 2'd3);
    send_coef(jhss_pkg::LAST_POS, '0, 2'd3, 2'd1, 2'd3);
    send_coef(jhss_pkg::LAST_POS, COEF_W'(-2048), 2'd3, 2'd1, 2'd0);
    r = '{op: jhss_pkg::OP_NOP, coef: '1, pos: '1, comp: '1, dct: '1, act: '1,
          is_ac: 1'b1, sym: '1};
    offer(r);
    send_read(2'd0, 1'b0, 8'd11);
    send_read(2'd3, 1'b0, 8'd12);
    send_read(2'd3, 1'b0, 8'd12);
    send_read(2'd1, 1'b0, 8'd0);
    send_read(2'd2, 1'b0, 8'd0);
    send_read(2'd0, 1'b0, 8'd255);
    send_read(2'd3, 1'b1, jhss_pkg::SYM_EOB);
    send_read(2'd3, 1'b1, 8'h3B);
    send_read(2'd3, 1'b1, 8'h01);
    send_read(2'd0, 1'b1, 8'h0C);
    send_read(2'd1, 1'b1, jhss_pkg::SYM_ZRL);
    send_op(jhss_pkg::OP_START);

    random_traffic(ITEM_TARGET / 3);
    drain();

    tx_idle_pct = 73;
    rx_idle_pct = 9;
    random_traffic(2 * ITEM_TARGET / 3);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // hold the receiver long enough for the result queue to back up into the input
    rx_hold_req = HOLD_CYCLES;
    send_reads(24);
    random_traffic(ITEM_TARGET);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
